FILE: rtl/jsd_pkg.sv
package jsd_pkg;

   localparam int unsigned LIMIT_WIDTH = 24;
   localparam int unsigned CSR_INDEX_WIDTH = 8;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_STRING_BYTES = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_TOTAL_BYTES = 8'd1;

   localparam logic [LIMIT_WIDTH-1:0] MAX_STRING_RESET = 24'd4096;
   localparam logic [LIMIT_WIDTH-1:0] MAX_TOTAL_RESET = 24'd65536;

   localparam logic [3:0] ST_OK = 4'd0;
   localparam logic [3:0] ST_NO_QUOTE = 4'd1;
   localparam logic [3:0] ST_CONTROL = 4'd2;
   localparam logic [3:0] ST_BAD_ESCAPE = 4'd3;
   localparam logic [3:0] ST_CUT_ESCAPE = 4'd4;
   localparam logic [3:0] ST_BAD_HEX = 4'd5;
   localparam logic [3:0] ST_CUT_HEX = 4'd6;
   localparam logic [3:0] ST_NO_LOW = 4'd7;
   localparam logic [3:0] ST_BAD_LOW = 4'd8;
   localparam logic [3:0] ST_LONE_LOW = 4'd9;
   localparam logic [3:0] ST_BAD_LEAD = 4'd10;
   localparam logic [3:0] ST_BAD_CONT = 4'd11;
   localparam logic [3:0] ST_CUT_UTF8 = 4'd12;
   localparam logic [3:0] ST_BAD_POINT = 4'd13;
   localparam logic [3:0] ST_LIMIT = 4'd14;
   localparam logic [3:0] ST_UNTERMINATED = 4'd15;

   typedef struct packed {
      logic [3:0][7:0] data;
      logic [2:0]      count;
   } enc_type;

   // one queued step: decoded bytes plus the status for its last beat
   typedef struct packed {
      logic [3:0][7:0] data;
      logic [2:0]      count;
      logic [3:0]      status;
      logic            done;
   } job_type;

   function automatic enc_type encode_point(input logic [20:0] cp);
      enc_type e;
      e.data = '0;
      if (cp <= 21'h7F) begin
         e.data[0] = cp[7:0];
         e.count = 3'd1;
      end else if (cp <= 21'h7FF) begin
         e.data[0] = {3'b110, cp[10:6]};
         e.data[1] = {2'b10, cp[5:0]};
         e.count = 3'd2;
      end else if (cp <= 21'hFFFF) begin
         e.data[0] = {4'b1110, cp[15:12]};
         e.data[1] = {2'b10, cp[11:6]};
         e.data[2] = {2'b10, cp[5:0]};
         e.count = 3'd3;
      end else begin
         e.data[0] = {5'b11110, cp[20:18]};
         e.data[1] = {2'b10, cp[17:12]};
         e.data[2] = {2'b10, cp[11:6]};
         e.data[3] = {2'b10, cp[5:0]};
         e.count = 3'd4;
      end
      return e;
   endfunction

endpackage

FILE: rtl/jsd_if.sv
interface jsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       input_end;
   modport source(output valid, output in_byte, output input_end, input ready);
   modport sink(input valid, input in_byte, input input_end, output ready);
endinterface

interface jsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic [3:0] status;
   logic       string_done;
   logic       last_result;
   modport source(output valid, output out_byte, output byte_valid, output status,
                  output string_done, output last_result, input ready);
   modport sink(input valid, input out_byte, input byte_valid, input status,
                input string_done, input last_result, output ready);
endinterface

interface jsd_csr_if;
   logic                                valid;
   logic                                ready;
   logic [jsd_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [jsd_pkg::LIMIT_WIDTH-1:0]     data;
   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface

FILE: rtl/jsd_front.sv
module jsd_front #(
   parameter int unsigned COUNT_WIDTH = 24
) (
   input  logic             clock,
   input  logic             reset,
   jsd_req_if.sink          req,
   jsd_csr_if.sink          csr,
   input  logic             queue_full,
   output logic             push,
   output jsd_pkg::job_type push_job
);

   localparam int unsigned EXT_WIDTH =
      (COUNT_WIDTH > jsd_pkg::LIMIT_WIDTH) ? COUNT_WIDTH : jsd_pkg::LIMIT_WIDTH;

   typedef enum logic [7:0] {
      PH_IDLE   = 8'b0000_0001,
      PH_STR    = 8'b0000_0010,
      PH_ESC    = 8'b0000_0100,
      PH_HEX1   = 8'b0000_1000,
      PH_SUR_BS = 8'b0001_0000,
      PH_SUR_U  = 8'b0010_0000,
      PH_HEX2   = 8'b0100_0000,
      PH_UTF    = 8'b1000_0000
   } phase_type;

   phase_type                        phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0]           str_len_ff, str_len_in;
   logic [COUNT_WIDTH-1:0]           total_ff, total_in;
   logic [15:0]                      hex_ff, hex_in;
   logic [9:0]                       high_ff, high_in;
   logic [2:0]                       digits_ff, digits_in;
   logic [20:0]                      cp_ff, cp_in;
   logic [3:0]                       pend_ff, pend_in;
   logic [1:0]                       seq_len_ff, seq_len_in;
   logic [jsd_pkg::LIMIT_WIDTH-1:0]  max_str_ff, max_total_ff;

   logic                   accept;
   logic [7:0]             b;
   logic                   emit_req;
   logic [20:0]            emit_cp;
   logic [3:0]             err;
   logic                   done;
   logic                   clear_len;
   jsd_pkg::enc_type       enc;
   logic [3:0]             dval;
   logic                   dok;
   logic [10:0]            first;
   logic [20:0]            pair_cp;
   logic [COUNT_WIDTH-1:0] len_sat [5];
   logic [COUNT_WIDTH-1:0] tot_sat [5];
   logic [COUNT_WIDTH:0]   sum_l, sum_t;
   logic [3:0]             pass;
   logic [2:0]             nout;
   logic                   run;

   assign accept = req.valid && req.ready;
   assign req.ready = !queue_full;
   assign csr.ready = 1'b1;
   assign b = req.in_byte;

   always_comb begin
      dok = 1'b1;
      dval = 4'hF;
      if (b >= 8'h30 && b <= 8'h39) begin
         dval = b[3:0];
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         dval = b[3:0] + 4'd9;
      end else begin
         dok = 1'b0;
      end
   end

   // saturating counts after j further bytes
   always_comb begin
      for (int j = 0; j < 5; j++) begin
         sum_l = {1'b0, str_len_ff} + (COUNT_WIDTH+1)'(j);
         sum_t = {1'b0, total_ff} + (COUNT_WIDTH+1)'(j);
         len_sat[j] = sum_l[COUNT_WIDTH] ? '1 : sum_l[COUNT_WIDTH-1:0];
         tot_sat[j] = sum_t[COUNT_WIDTH] ? '1 : sum_t[COUNT_WIDTH-1:0];
      end
      for (int j = 0; j < 4; j++) begin
         pass[j] = (EXT_WIDTH'(len_sat[j]) < EXT_WIDTH'(max_str_ff)) &&
                   (EXT_WIDTH'(tot_sat[j]) < EXT_WIDTH'(max_total_ff));
      end
   end

   always_comb begin
      phase_in = phase_ff;
      hex_in = hex_ff;
      high_in = high_ff;
      digits_in = digits_ff;
      cp_in = cp_ff;
      pend_in = pend_ff;
      seq_len_in = seq_len_ff;
      emit_req = 1'b0;
      emit_cp = {13'd0, b};
      err = jsd_pkg::ST_OK;
      done = 1'b0;
      clear_len = 1'b0;
      first = {cp_ff[4:0], b[5:0]};
      pair_cp = 21'h10000 + {1'b0, high_ff, hex_in[9:0]};

      case (phase_ff)
         PH_IDLE: begin
            if (b != 8'h22) begin
               err = jsd_pkg::ST_NO_QUOTE;
            end else begin
               clear_len = 1'b1;
               phase_in = PH_STR;
            end
         end
         PH_STR: begin
            if (b == 8'h22) begin
               done = 1'b1;
               phase_in = PH_IDLE;
            end else if (b == 8'h5C) begin
               phase_in = PH_ESC;
            end else if (b < 8'h20) begin
               err = jsd_pkg::ST_CONTROL;
            end else if (b < 8'h80) begin
               emit_req = 1'b1;
            end else begin
               if (b >= 8'hC2 && b <= 8'hDF) begin
                  seq_len_in = 2'd1;
                  cp_in = {16'd0, b[4:0]};
               end else if (b >= 8'hE0 && b <= 8'hEF) begin
                  seq_len_in = 2'd2;
                  cp_in = {17'd0, b[3:0]};
               end else if (b >= 8'hF0 && b <= 8'hF4) begin
                  seq_len_in = 2'd3;
                  cp_in = {18'd0, b[2:0]};
               end else begin
                  err = jsd_pkg::ST_BAD_LEAD;
               end
               if (err == jsd_pkg::ST_OK) begin
                  digits_in = {1'b0, seq_len_in};
                  pend_in = jsd_pkg::ST_OK;
                  phase_in = PH_UTF;
               end
            end
         end
         PH_ESC: begin
            phase_in = PH_STR;
            emit_req = 1'b1;
            case (b)
               8'h22, 8'h5C, 8'h2F: emit_cp = {13'd0, b};
               8'h62: emit_cp = 21'h08;
               8'h66: emit_cp = 21'h0C;
               8'h6E: emit_cp = 21'h0A;
               8'h72: emit_cp = 21'h0D;
               8'h74: emit_cp = 21'h09;
               8'h75: begin
                  emit_req = 1'b0;
                  phase_in = PH_HEX1;
                  digits_in = 3'd0;
                  hex_in = 16'd0;
                  pend_in = jsd_pkg::ST_OK;
               end
               default: begin
                  emit_req = 1'b0;
                  err = jsd_pkg::ST_BAD_ESCAPE;
               end
            endcase
         end
         PH_HEX1, PH_HEX2: begin
            if (!dok && pend_ff == jsd_pkg::ST_OK) pend_in = jsd_pkg::ST_BAD_HEX;
            hex_in = {hex_ff[11:0], dval};
            digits_in = digits_ff + 3'd1;
            pair_cp = 21'h10000 + {1'b0, high_ff, hex_in[9:0]};
            if (digits_in >= 3'd4) begin
               if (pend_in != jsd_pkg::ST_OK) begin
                  err = pend_in;
               end else if (phase_ff == PH_HEX1) begin
                  if (hex_in >= 16'hD800 && hex_in <= 16'hDBFF) begin
                     high_in = hex_in[9:0];
                     phase_in = PH_SUR_BS;
                  end else if (hex_in >= 16'hDC00 && hex_in <= 16'hDFFF) begin
                     err = jsd_pkg::ST_LONE_LOW;
                  end else begin
                     phase_in = PH_STR;
                     emit_req = 1'b1;
                     emit_cp = {5'd0, hex_in};
                  end
               end else begin
                  if (hex_in < 16'hDC00 || hex_in > 16'hDFFF) begin
                     err = jsd_pkg::ST_BAD_LOW;
                  end else begin
                     phase_in = PH_STR;
                     emit_req = 1'b1;
                     emit_cp = pair_cp;
                  end
               end
            end
         end
         PH_SUR_BS: begin
            if (b != 8'h5C) err = jsd_pkg::ST_NO_LOW;
            else phase_in = PH_SUR_U;
         end
         PH_SUR_U: begin
            if (b != 8'h75) begin
               err = jsd_pkg::ST_NO_LOW;
            end else begin
               phase_in = PH_HEX2;
               digits_in = 3'd0;
               hex_in = 16'd0;
               pend_in = jsd_pkg::ST_OK;
            end
         end
         PH_UTF: begin
            if (b[7:6] != 2'b10) begin
               pend_in = jsd_pkg::ST_BAD_CONT;
            end else if (pend_ff == jsd_pkg::ST_OK && digits_ff == {1'b0, seq_len_ff}) begin
               // overlong three and four byte forms show in the first continuation
               if ((seq_len_ff == 2'd2 && cp_ff[20:5] == '0 && first < 11'h20) ||
                   (seq_len_ff == 2'd3 && cp_ff[20:5] == '0 && first < 11'h10))
                  pend_in = jsd_pkg::ST_BAD_POINT;
            end
            cp_in = {cp_ff[14:0], b[5:0]};
            if (digits_ff != 3'd0) digits_in = digits_ff - 3'd1;
            if (digits_in == 3'd0) begin
               if (pend_in != jsd_pkg::ST_OK) begin
                  err = pend_in;
               end else if ((cp_in >= 21'hD800 && cp_in <= 21'hDFFF) ||
                            cp_in > 21'h10FFFF ||
                            (seq_len_ff == 2'd1 && cp_in < 21'h80)) begin
                  err = jsd_pkg::ST_BAD_POINT;
               end else begin
                  phase_in = PH_STR;
                  emit_req = 1'b1;
                  emit_cp = cp_in;
               end
            end
         end
         default: phase_in = PH_IDLE;
      endcase

      enc = jsd_pkg::encode_point(emit_cp);
      nout = 3'd0;
      run = emit_req;
      for (int j = 0; j < 4; j++) begin
         if (run && (3'(j) < enc.count) && pass[j]) nout = nout + 3'd1;
         else run = 1'b0;
      end
      if (emit_req && nout < enc.count) err = jsd_pkg::ST_LIMIT;

      if (err == jsd_pkg::ST_OK && req.input_end && phase_in != PH_IDLE) begin
         case (phase_in)
            PH_STR:              err = jsd_pkg::ST_UNTERMINATED;
            PH_ESC:              err = jsd_pkg::ST_CUT_ESCAPE;
            PH_HEX1, PH_HEX2:    err = jsd_pkg::ST_CUT_HEX;
            PH_SUR_BS, PH_SUR_U: err = jsd_pkg::ST_NO_LOW;
            default:             err = jsd_pkg::ST_CUT_UTF8;
         endcase
      end
      if (err != jsd_pkg::ST_OK) phase_in = PH_IDLE;

      str_len_in = clear_len ? '0 : len_sat[nout];
      total_in = tot_sat[nout];

      push_job.data = enc.data;
      push_job.count = nout;
      push_job.status = err;
      push_job.done = done;
      push = accept && (nout != 3'd0 || err != jsd_pkg::ST_OK || done);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         str_len_ff <= '0;
         total_ff <= '0;
         hex_ff <= '0;
         high_ff <= '0;
         digits_ff <= '0;
         cp_ff <= '0;
         pend_ff <= '0;
         seq_len_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         str_len_ff <= str_len_in;
         total_ff <= total_in;
         hex_ff <= hex_in;
         high_ff <= high_in;
         digits_ff <= digits_in;
         cp_ff <= cp_in;
         pend_ff <= pend_in;
         seq_len_ff <= seq_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_str_ff <= jsd_pkg::MAX_STRING_RESET;
         max_total_ff <= jsd_pkg::MAX_TOTAL_RESET;
      end else if (csr.valid) begin
         if (csr.index == jsd_pkg::CSR_MAX_STRING_BYTES) max_str_ff <= csr.data;
         else if (csr.index == jsd_pkg::CSR_MAX_TOTAL_BYTES) max_total_ff <= csr.data;
      end
   end

endmodule

FILE: rtl/jsd_queue.sv
module jsd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jsd_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output jsd_pkg::job_type head,
   output logic             empty
);

   jsd_pkg::job_type                  slot_ff [jsd_pkg::QUEUE_DEPTH];
   logic [jsd_pkg::QPTR_WIDTH-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [jsd_pkg::QPTR_WIDTH:0]      fill_ff, fill_in;

   assign full = (fill_ff == (jsd_pkg::QPTR_WIDTH+1)'(jsd_pkg::QUEUE_DEPTH));
   assign empty = (fill_ff == '0);
   assign head = slot_ff[rd_ff];

   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      fill_in = fill_ff;
      if (push && !pop) fill_in = fill_ff + 1'b1;
      else if (pop && !push) fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_job;
   end

endmodule

FILE: rtl/jsd_back.sv
module jsd_back (
   input  logic             clock,
   input  logic             reset,
   input  jsd_pkg::job_type head,
   input  logic             empty,
   output logic             pop,
   jsd_rsp_if.source        rsp
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       bvalid_ff, bvalid_in;
   logic [3:0] status_ff, status_in;
   logic       done_ff, done_in;
   logic       last_ff, last_in;
   logic       load;
   logic       has_data;
   logic       is_last;

   assign load = !valid_ff || rsp.ready;
   assign has_data = (head.count != 3'd0);
   // a step with no data still yields one status beat
   assign is_last = !has_data || ({1'b0, idx_ff} == head.count - 3'd1);
   assign pop = load && !empty && is_last;

   always_comb begin
      valid_in = valid_ff;
      idx_in = idx_ff;
      byte_in = byte_ff;
      bvalid_in = bvalid_ff;
      status_in = status_ff;
      done_in = done_ff;
      last_in = last_ff;
      if (load) begin
         valid_in = !empty;
         byte_in = has_data ? head.data[idx_ff] : 8'd0;
         bvalid_in = has_data;
         status_in = is_last ? head.status : jsd_pkg::ST_OK;
         done_in = is_last && head.done;
         last_in = is_last;
         if (!empty) idx_in = is_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      bvalid_ff <= bvalid_in;
      status_ff <= status_in;
      done_ff <= done_in;
      last_ff <= last_in;
   end

   assign rsp.valid = valid_ff;
   assign rsp.out_byte = byte_ff;
   assign rsp.byte_valid = bvalid_ff;
   assign rsp.status = status_ff;
   assign rsp.string_done = done_ff;
   assign rsp.last_result = last_ff;

   a_partial_job_queued: assert property (@(posedge clock) disable iff (reset)
      idx_ff != 2'd0 |-> !empty)
      else $error("beat index set with nothing queued");

   a_status_beat_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !bvalid_ff) |-> (last_ff && byte_ff == 8'd0))
      else $error("status-only beat not final or carries data");

   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && done_ff) |-> (status_ff == jsd_pkg::ST_OK && !bvalid_ff))
      else $error("close beat carries data or error");

endmodule

FILE: rtl/json_string_decoder_core.sv
// JSON string decoder.
// req_chan carries raw token bytes (in_byte, input_end), one beat per byte,
// starting at the opening quote. rsp_chan returns the decoded UTF-8 bytes,
// 0 to 4 beats per input byte; errors and the close ride on the last beat of
// that byte, or on a data-less beat; last_result marks the final beat of each step.
// csr_chan writes the two limits: index 0 per-string, index 1 running total.
// It is always ready; write it only while the block is idle.
// A four-entry queue of decoded steps sits between input decoding and the
// output register. Decoding takes one byte per cycle while the queue has
// room; req_chan.ready drops only while it is full. The output register
// delivers one beat per cycle while rsp_chan is ready, so a byte giving
// several beats holds the output side for all of them. A stalled rsp_chan
// holds its beat and lets the queue fill behind it.
// Reset (synchronous) returns to idle awaiting a quote, clears the byte
// counts and the queue, and sets the limits to 4096 and 65536.
module json_string_decoder_core #(
   parameter int unsigned COUNT_WIDTH = 24
) (
   input logic       clock,
   input logic       reset,
   jsd_req_if.sink   req_chan,
   jsd_rsp_if.source rsp_chan,
   jsd_csr_if.sink   csr_chan
);

   logic             push;
   logic             pop;
   logic             full;
   logic             empty;
   jsd_pkg::job_type push_job;
   jsd_pkg::job_type head;

   jsd_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
      .clock(clock),
      .reset(reset),
      .req(req_chan),
      .csr(csr_chan),
      .queue_full(full),
      .push(push),
      .push_job(push_job)
   );

   jsd_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_job(push_job),
      .full(full),
      .pop(pop),
      .head(head),
      .empty(empty)
   );

   jsd_back u_back (
      .clock(clock),
      .reset(reset),
      .head(head),
      .empty(empty),
      .pop(pop),
      .rsp(rsp_chan)
   );

endmodule
